// ===== src/crs_pkg.sv =====
// Package: shared types, constants and an arithmetic helper for the spline evaluator.
package crs_pkg;
  localparam int MaxPoints  = 16;
  localparam int CoordWidth = 32;
  localparam int SlotWidth  = $clog2(MaxPoints);
  localparam int CntWidth   = $clog2(MaxPoints + 1);
  localparam int TWidth     = 17;
  localparam int FracWidth  = 17;
  localparam int AccWidth   = CoordWidth + 8;
  localparam int QDepth     = 2;
  localparam logic [TWidth-1:0] TOne = TWidth'(65536);

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef struct packed {
    logic [SlotWidth-1:0] i0;
    logic [SlotWidth-1:0] i1;
    logic [SlotWidth-1:0] i2;
    logic [SlotWidth-1:0] i3;
    logic [FracWidth-1:0] frac;
  } job_t;

  // round(a*f/2^16), halves upward; exact via arithmetic shift
  function automatic logic signed [AccWidth-1:0] mul_frac(
      input logic signed [AccWidth-1:0] a, input logic [FracWidth-1:0] f);
    logic signed [AccWidth+FracWidth:0] p;
    begin
      p = a * $signed({1'b0, f});
      p = p + (AccWidth+FracWidth+1)'(32768);
      mul_frac = AccWidth'(p >>> 16);
    end
  endfunction
endpackage

// ===== src/crs_ram.sv =====
// Generic single-write, registered-read RAM.
module crs_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/crs_front.sv =====
// Front end: decodes evaluate words into segment indices and fraction.
module crs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid,
  input  logic [crs_pkg::CntWidth-1:0]  point_count,
  input  logic [crs_pkg::TWidth-1:0]    param_t,
  input  logic                          q_full,
  output logic                          q_push,
  output crs_pkg::job_t                 q_job
);
  import crs_pkg::*;
  logic [CntWidth-1:0] n;
  logic [CntWidth-1:0] d;
  logic [TWidth-1:0]   t;
  logic [TWidth+CntWidth-1:0] s;
  logic [CntWidth-1:0] seg;
  logic [FracWidth-1:0] f;
  logic                valid_r;
  job_t                job_r;
  job_t                job_nxt;

  always_comb begin
    n = point_count;
    if (n < CntWidth'(4)) n = CntWidth'(4);
    if (n > CntWidth'(MaxPoints)) n = CntWidth'(MaxPoints);
    d = n - CntWidth'(1);
    t = (param_t > TOne) ? TOne : param_t;
    s = t * d;
    seg = CntWidth'(s >> 16);
    f = {1'b0, s[15:0]};
    if (seg >= d) begin
      seg = d - CntWidth'(1);
      f = TOne;
    end
    job_nxt.i1 = SlotWidth'(seg);
    job_nxt.i2 = SlotWidth'(seg + CntWidth'(1));
    job_nxt.i0 = (seg == '0) ? SlotWidth'(seg) : SlotWidth'(seg - CntWidth'(1));
    job_nxt.i3 = (seg + CntWidth'(2) >= n) ? SlotWidth'(seg + CntWidth'(1))
                                           : SlotWidth'(seg + CntWidth'(2));
    job_nxt.frac = f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (valid) valid_r <= 1'b1;
    else if (!q_full) valid_r <= 1'b0;
    if (valid) job_r <= job_nxt;
  end

  assign q_push = valid_r && !q_full;
  assign q_job  = job_r;
endmodule

// ===== src/crs_queue.sv =====
// Short job queue between front and back ends.
module crs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  crs_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output crs_pkg::job_t head
);
  import crs_pkg::*;
  localparam int PW = $clog2(QDepth);
  job_t          q_r [QDepth];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop) rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
    if (push) q_r[wp_r] <= push_job;
  end

  assign full = cnt_r == (PW+1)'(QDepth);
  assign not_empty = cnt_r != '0;
  assign head = q_r[rp_r];
endmodule

// ===== src/crs_back.sv =====
// Back end: reads four points per axis and runs Horner with one shared multiplier.
module crs_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  input  crs_pkg::job_t                  job,
  output logic                           job_pop,
  input  logic                           ld_we,
  input  logic [crs_pkg::SlotWidth-1:0]  ld_slot,
  input  logic [crs_pkg::CoordWidth-1:0] ld_x,
  input  logic [crs_pkg::CoordWidth-1:0] ld_y,
  input  logic [crs_pkg::CoordWidth-1:0] ld_z,
  output logic                           idle,
  output logic                           res_valid,
  output logic [crs_pkg::CoordWidth-1:0] res_x,
  output logic [crs_pkg::CoordWidth-1:0] res_y,
  output logic [crs_pkg::CoordWidth-1:0] res_z
);
  import crs_pkg::*;
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_COEF = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] rc_r;
  logic [1:0] ax_r;
  logic [1:0] hs_r;
  job_t job_r;
  logic [SlotWidth-1:0] raddr;
  logic [CoordWidth-1:0] rx, ry, rz;
  logic signed [CoordWidth-1:0] px_r [4];
  logic signed [CoordWidth-1:0] py_r [4];
  logic signed [CoordWidth-1:0] pz_r [4];
  logic signed [AccWidth-1:0] e_r [3][4];
  logic signed [AccWidth-1:0] acc_r;
  logic signed [AccWidth-1:0] mres;
  logic [CoordWidth-1:0] ox_r, oy_r, oz_r;
  logic rv_r;
  logic [2:0] rdv_r;
  logic [1:0] rdi_r;
  localparam logic signed [AccWidth-1:0] Hi = AccWidth'((64'sd1 <<< (CoordWidth-1)) - 1);
  localparam logic signed [AccWidth-1:0] Lo = -Hi - AccWidth'(1);

  function automatic logic signed [AccWidth-1:0] sx(input logic signed [CoordWidth-1:0] v);
    sx = AccWidth'(v);
  endfunction

  always_comb begin
    case (rc_r)
      2'd0: raddr = job_r.i0;
      2'd1: raddr = job_r.i1;
      2'd2: raddr = job_r.i2;
      default: raddr = job_r.i3;
    endcase
  end

  crs_ram #(.Width(CoordWidth), .Depth(MaxPoints)) u_rx (
    .clk, .we(ld_we), .waddr(ld_slot), .wdata(ld_x), .raddr, .rdata(rx));
  crs_ram #(.Width(CoordWidth), .Depth(MaxPoints)) u_ry (
    .clk, .we(ld_we), .waddr(ld_slot), .wdata(ld_y), .raddr, .rdata(ry));
  crs_ram #(.Width(CoordWidth), .Depth(MaxPoints)) u_rz (
    .clk, .we(ld_we), .waddr(ld_slot), .wdata(ld_z), .raddr, .rdata(rz));

  assign mres = mul_frac(acc_r, job_r.frac);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (job_valid) state_nxt = S_READ;
      S_READ: if (rdv_r[2] && rdi_r == 2'd3) state_nxt = S_COEF;
      S_COEF: state_nxt = S_MUL;
      S_MUL:  if (ax_r == 2'd2 && hs_r == 2'd3) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rv_r <= 1'b0;
      rdv_r <= '0;
    end else begin
      state_r <= state_nxt;
      rv_r <= state_r == S_DONE;
      rdv_r <= {rdv_r[1:0], state_r == S_READ};
      if (state_r != S_READ) rdv_r <= '0;
      if (state_r == S_IDLE && job_valid) rdv_r <= 3'b001;
    end
    case (state_r)
      S_IDLE: begin
        rc_r <= '0;
        if (job_valid) job_r <= job;
      end
      S_READ: begin
        if (rc_r != 2'd3) rc_r <= rc_r + 2'd1;
        rdi_r <= rc_r;
        if (rdv_r[1]) begin
          px_r[rdi_r] <= rx;
          py_r[rdi_r] <= ry;
          pz_r[rdi_r] <= rz;
        end
      end
      S_COEF: begin
        if (rdv_r[1]) begin
          px_r[rdi_r] <= rx;
          py_r[rdi_r] <= ry;
          pz_r[rdi_r] <= rz;
        end
        ax_r <= '0;
        hs_r <= '0;
      end
      S_MUL: begin
        if (hs_r == 2'd0) acc_r <= e_r[ax_r][3];
        else if (hs_r == 2'd3) begin
          acc_r <= '0;
        end else acc_r <= mres + e_r[ax_r][2'd3 - hs_r];
        if (hs_r == 2'd3) begin
          ax_r <= ax_r + 2'd1;
          hs_r <= '0;
        end else hs_r <= hs_r + 2'd1;
      end
      default: ;
    endcase
  end

  // final step folds e0 in and rounds the same cycle via acc_fin
  logic signed [AccWidth-1:0] acc_fin;
  logic signed [AccWidth-1:0] rf;
  logic [CoordWidth-1:0] satf;
  always_comb begin
    acc_fin = mres + e_r[ax_r][0];
    rf = (acc_fin + AccWidth'(1)) >>> 1;
    if (rf > Hi) satf = CoordWidth'(Hi);
    else if (rf < Lo) satf = CoordWidth'(Lo);
    else satf = CoordWidth'(rf);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL && hs_r == 2'd3) begin
      case (ax_r)
        2'd0: ox_r <= satf;
        2'd1: oy_r <= satf;
        default: oz_r <= satf;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_COEF) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [AccWidth-1:0] q0, q1, q2, q3;
        q0 = (a == 0) ? sx(px_r[0]) : (a == 1) ? sx(py_r[0]) : sx(pz_r[0]);
        q1 = (a == 0) ? sx(px_r[1]) : (a == 1) ? sx(py_r[1]) : sx(pz_r[1]);
        q2 = (a == 0) ? sx(px_r[2]) : (a == 1) ? sx(py_r[2]) : sx(pz_r[2]);
        q3 = (a == 0) ? sx(px_r[3]) : (a == 1) ? sx(py_r[3]) : sx(pz_r[3]);
        e_r[a][3] <= -q0 + (q1 <<< 1) + q1 - (q2 <<< 1) - q2 + q3;
        e_r[a][2] <= (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
        e_r[a][1] <= q2 - q0;
        e_r[a][0] <= q1 <<< 1;
      end
    end
  end

  assign job_pop = state_r == S_IDLE && job_valid;
  assign idle = state_r == S_IDLE;
  assign res_valid = rv_r;
  assign res_x = ox_r;
  assign res_y = oy_r;
  assign res_z = oz_r;
endmodule

// ===== src/catmull_rom_spline_eval_core.sv =====
// Top level: uniform Catmull-Rom spline evaluator over 16 stored 3D points.
// Usage:
//   Input words: start with in_operation; busy high means not taken.
//   A load (operation 0) writes in_slot with in_point_x/y/z into the store
//   in the accepting cycle; it gives no result.
//   An evaluate (operation 1) takes in_param_t (Q1.16, 65536 = 1.0) and
//   yields one word on out_x/out_y/out_z marked by out_valid.
//   The back end of an evaluate does four store reads and then the
//   3 axes x 4 Horner steps on the one shared multiplier. A two-deep
//   queue sits between the front and back end; busy rises while it is
//   full, and until then evaluates are taken while the back end is still
//   working on earlier ones. Loads are taken every cycle while no
//   evaluate is pending.
//   cfg_we/cfg_data write point_count (clamped to 4..16 at use).
//   Reset (rst_n low, synchronous) empties the queue and sets point_count
//   to 4; the store keeps its contents and must be loaded before use.
//   The receiver cannot stall: each result is shown for one cycle only.
module catmull_rom_spline_eval_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_operation,
  input  logic [crs_pkg::SlotWidth-1:0]         in_slot,
  input  logic signed [crs_pkg::CoordWidth-1:0] in_point_x,
  input  logic signed [crs_pkg::CoordWidth-1:0] in_point_y,
  input  logic signed [crs_pkg::CoordWidth-1:0] in_point_z,
  input  logic [crs_pkg::TWidth-1:0]            in_param_t,
  input  logic                                  cfg_we,
  input  logic [crs_pkg::CntWidth-1:0]          cfg_data,
  output logic                                  out_valid,
  output logic signed [crs_pkg::CoordWidth-1:0] out_x,
  output logic signed [crs_pkg::CoordWidth-1:0] out_y,
  output logic signed [crs_pkg::CoordWidth-1:0] out_z
);
  import crs_pkg::*;
  logic [CntWidth-1:0] cnt_r;
  logic acc, ev, ld, pend;
  logic q_push, q_full, q_ne, q_pop, b_idle;
  job_t f_job, q_head;
  logic fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= CntWidth'(4);
    else if (cfg_we) cnt_r <= cfg_data;
    if (!rst_n) fv_r <= 1'b0;
    else if (ev) fv_r <= 1'b1;
    else if (q_push) fv_r <= 1'b0;
  end

  assign pend = fv_r || q_ne || !b_idle;
  assign busy = q_full || fv_r || (pend && in_operation == OP_LOAD);
  assign acc = start && !busy;
  assign ev = acc && in_operation == OP_EVAL;
  assign ld = acc && in_operation == OP_LOAD;

  crs_front u_front (.clk, .rst_n, .valid(ev), .point_count(cnt_r),
    .param_t(in_param_t), .q_full, .q_push, .q_job(f_job));
  crs_queue u_queue (.clk, .rst_n, .push(q_push), .push_job(f_job),
    .pop(q_pop), .full(q_full), .not_empty(q_ne), .head(q_head));
  crs_back u_back (.clk, .rst_n, .job_valid(q_ne), .job(q_head), .job_pop(q_pop),
    .ld_we(ld), .ld_slot(in_slot), .ld_x(in_point_x), .ld_y(in_point_y),
    .ld_z(in_point_z), .idle(b_idle), .res_valid(out_valid),
    .res_x(out_x), .res_y(out_y), .res_z(out_z));
endmodule

// ===== src/crs_checker.sv =====
// Checker: port-level properties of the spline evaluator, bound to the top level.
module crs_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_operation,
  input logic out_valid
);
  a_no_back2back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("results in consecutive cycles");
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation) |=> busy) else $error("not busy after evaluate");
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");
endmodule

bind catmull_rom_spline_eval_core crs_checker u_crs_checker (
  .clk, .rst_n, .start, .busy, .in_operation, .out_valid);
